// ----- rtl/mono_framebuffer_draw_engine_assert.svh -----
// assertion macros used by the frame store draw engine checker
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define MFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfb: next-cycle check failed");

// consequent must hold in the same cycle as the antecedent
`define MFB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfb: same-cycle check failed");

`endif

// ----- rtl/mfb_pkg.sv -----
// types and constants of the frame store draw engine
`default_nettype none

package mfb_pkg;

   // command codes of the request word
   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_PIXEL = 2'd1,
      CMD_BAR   = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_PIXEL_WR,
      ST_BAR_MUL,
      ST_BAR_DIV,
      ST_BAR_FILL,
      ST_DONE
   } state_type;

   // bar fill patterns
   localparam logic [7:0] BORDER_PATTERN  = 8'h7E;
   localparam logic [7:0] OUTLINE_PATTERN = 8'h42;

   // percent clamp and divide by 100 as multiply by 5243 / 2^19
   localparam logic [6:0]  FULL_PERCENT = 7'd100;
   localparam logic [12:0] RECIP_100    = 13'd5243;
   localparam int          RECIP_SHIFT  = 19;

endpackage

`default_nettype wire

// ----- rtl/mono_framebuffer_draw_engine.sv -----
// page organized monochrome frame store with clear, pixel, bar and read commands
// read answers from the registered ram read, pixel is a read-modify-write, bar steps
// through multiply, divide and fill states, clear sweeps all DEPTH bytes; one command in
// flight on the single ram write port, so no new word is taken until the last one is through;
// the result register lets the next word be accepted while a result waits
// reset: a clearing pass writes zero to all DEPTH bytes (1024 at 128x64) with req_ready low
`default_nettype none

module mono_framebuffer_draw_engine #(
   parameter int WIDTH  = 128,
   parameter int HEIGHT = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_cmd,
   input  wire logic [7:0] req_x_pos,
   input  wire logic [7:0] req_y_pos,
   input  wire logic       req_pixel_on,
   input  wire logic [7:0] req_bar_end,
   input  wire logic [7:0] req_percent,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_byte,
   output logic            rsp_accepted
);

   localparam int PAGES  = (HEIGHT + 7) / 8;
   localparam int DEPTH  = WIDTH * PAGES;
   localparam int ADDR_W = $clog2(DEPTH);

   mfb_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   mfb_pkg::cmd_type   cmd_ff;
   logic               acc_ff;
   logic               on_ff;
   logic [2:0]         bit_ff;
   logic [7:0]         span_ff;
   logic [6:0]         pct_ff;
   logic [15:0]        prod_ff;
   logic [8:0]         filled_ff;
   logic [7:0]         col_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_byte_ff;
   logic               rsp_acc_ff;

   mfb_pkg::cmd_type   req_cmd_e;
   logic               accept;
   logic               req_ok;
   logic               x_ok;
   logic [ADDR_W-1:0]  page_addr;
   logic [ADDR_W-1:0]  read_addr;
   logic               last_addr;
   logic               rsp_load;
   logic [8:0]         bar_w;
   logic [7:0]         pix_mask;
   logic [7:0]         bar_pattern;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [7:0]         wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [7:0]         rd_data;

   // frame store
   mfb_ram #(
      .DATA_W (8),
      .DEPTH  (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // request decode and bounds checks
   always_comb begin
      req_cmd_e = mfb_pkg::cmd_type'(req_cmd);
      x_ok      = {1'b0, req_x_pos} < 9'(WIDTH);
      page_addr = ADDR_W'(int'(req_y_pos[7:3]) * WIDTH + int'(req_x_pos));
      read_addr = ADDR_W'(int'(req_y_pos) * WIDTH + int'(req_x_pos));
      unique case (req_cmd_e)
         mfb_pkg::CMD_CLEAR: req_ok = 1'b1;
         mfb_pkg::CMD_PIXEL: req_ok = x_ok && (req_y_pos < 8'(HEIGHT));
         mfb_pkg::CMD_BAR:   req_ok = (req_x_pos < req_bar_end)
                                      && ({1'b0, req_bar_end} < 9'(WIDTH))
                                      && (req_y_pos[7:3] < 5'(PAGES));
         mfb_pkg::CMD_READ:  req_ok = x_ok && (req_y_pos < 8'(PAGES));
         default:            req_ok = 1'b0;
      endcase
   end

   // shared datapath terms
   always_comb begin
      accept      = req_valid && req_ready;
      last_addr   = addr_ff == ADDR_W'(DEPTH - 1);
      rsp_load    = (state_ff == mfb_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
      bar_w       = {1'b0, span_ff} + 9'd1;
      pix_mask    = 8'd1 << bit_ff;
      bar_pattern = ((col_ff == 8'd0) || (col_ff == span_ff) || ({1'b0, col_ff} <= filled_ff))
                    ? mfb_pkg::BORDER_PATTERN : mfb_pkg::OUTLINE_PATTERN;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfb_pkg::ST_INIT: begin
            if (last_addr) state_in = mfb_pkg::ST_IDLE;
         end
         mfb_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd_e)
                  mfb_pkg::CMD_CLEAR: state_in = mfb_pkg::ST_CLEAR;
                  mfb_pkg::CMD_PIXEL: state_in = req_ok ? mfb_pkg::ST_PIXEL_WR
                                                        : mfb_pkg::ST_DONE;
                  mfb_pkg::CMD_BAR:   state_in = req_ok ? mfb_pkg::ST_BAR_MUL
                                                        : mfb_pkg::ST_DONE;
                  mfb_pkg::CMD_READ:  state_in = mfb_pkg::ST_DONE;
                  default:            state_in = mfb_pkg::ST_DONE;
               endcase
            end
         end
         mfb_pkg::ST_CLEAR: begin
            if (last_addr) state_in = mfb_pkg::ST_DONE;
         end
         mfb_pkg::ST_PIXEL_WR: state_in = mfb_pkg::ST_DONE;
         mfb_pkg::ST_BAR_MUL:  state_in = mfb_pkg::ST_BAR_DIV;
         mfb_pkg::ST_BAR_DIV:  state_in = mfb_pkg::ST_BAR_FILL;
         mfb_pkg::ST_BAR_FILL: begin
            if (col_ff == span_ff) state_in = mfb_pkg::ST_DONE;
         end
         mfb_pkg::ST_DONE: begin
            if (rsp_load) state_in = mfb_pkg::ST_IDLE;
         end
         default: state_in = mfb_pkg::ST_IDLE;
      endcase
   end

   // state outputs: handshake and ram ports
   always_comb begin
      req_ready = state_ff == mfb_pkg::ST_IDLE;
      wr_en     = 1'b0;
      wr_addr   = addr_ff;
      wr_data   = 8'd0;
      unique case (state_ff)
         mfb_pkg::ST_INIT, mfb_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
         end
         mfb_pkg::ST_PIXEL_WR: begin
            wr_en   = 1'b1;
            wr_data = on_ff ? (rd_data | pix_mask) : (rd_data & ~pix_mask);
         end
         mfb_pkg::ST_BAR_FILL: begin
            wr_en   = 1'b1;
            wr_data = bar_pattern;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
      rd_en   = accept && req_ok
                && ((req_cmd_e == mfb_pkg::CMD_PIXEL) || (req_cmd_e == mfb_pkg::CMD_READ));
      rd_addr = (req_cmd_e == mfb_pkg::CMD_READ) ? read_addr : page_addr;
   end

   // address counter: sweeps for the reset pass, clear and bar, target byte for pixel
   always_comb begin
      addr_in = addr_ff;
      priority if (accept) begin
         addr_in = (req_cmd_e == mfb_pkg::CMD_CLEAR) ? '0 : page_addr;
      end else if ((state_ff == mfb_pkg::ST_INIT) || (state_ff == mfb_pkg::ST_CLEAR)
                   || (state_ff == mfb_pkg::ST_BAR_FILL)) begin
         addr_in = addr_ff + ADDR_W'(1);
      end else begin
         addr_in = addr_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfb_pkg::ST_INIT;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // command word capture and bar arithmetic
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd_e;
         acc_ff <= req_ok;
         on_ff  <= req_pixel_on;
         bit_ff <= req_y_pos[2:0];
         span_ff <= req_bar_end - req_x_pos;
         pct_ff  <= (req_percent > 8'(mfb_pkg::FULL_PERCENT))
                    ? mfb_pkg::FULL_PERCENT : req_percent[6:0];
         col_ff  <= 8'd0;
      end
      if (state_ff == mfb_pkg::ST_BAR_MUL) begin
         prod_ff <= 16'(bar_w) * 16'(pct_ff);
      end
      if (state_ff == mfb_pkg::ST_BAR_DIV) begin
         filled_ff <= 9'((32'(prod_ff) * 32'(mfb_pkg::RECIP_100)) >> mfb_pkg::RECIP_SHIFT);
      end
      if (state_ff == mfb_pkg::ST_BAR_FILL) begin
         col_ff <= col_ff + 8'd1;
      end
      if (rsp_load) begin
         rsp_byte_ff <= ((cmd_ff == mfb_pkg::CMD_READ) && acc_ff) ? rd_data : 8'd0;
         rsp_acc_ff  <= acc_ff;
      end
   end

   // result word
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_byte_ff;
   assign rsp_accepted  = rsp_acc_ff;

endmodule

`default_nettype wire

// ----- rtl/mfb_ram.sv -----
// generic simple dual port ram with registered read
`default_nettype none

module mfb_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mfb_checker.sv -----
// port level checks of the frame store draw engine, bound to the top level
`default_nettype none

`include "mono_framebuffer_draw_engine_assert.svh"

module mfb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_cmd,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_read_byte,
   input wire logic       rsp_accepted
);

   logic clear_accept;
   logic rsp_stall;

   // clear word taken and result stalled
   assign clear_accept = req_valid && req_ready && (req_cmd == mfb_pkg::CMD_CLEAR);
   assign rsp_stall    = rsp_valid && !rsp_ready;

   // stalled result word holds
   `MFB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_read_byte) && $stable(rsp_accepted))

   // a nonzero byte only comes from an accepted read
   `MFB_ASSERT_NOW(a_byte_acc, clock, reset, rsp_valid && (rsp_read_byte != 8'd0), rsp_accepted)

   // reset starts the clearing pass with no result pending
   `MFB_ASSERT_NEXT(a_reset_busy, clock, 1'b0, reset, !req_ready && !rsp_valid)

   // clear command sweeps the store before taking another word
   `MFB_ASSERT_NEXT(a_clear_busy, clock, reset, clear_accept, !req_ready)

endmodule

bind mono_framebuffer_draw_engine mfb_checker u_mfb_checker (.*);

`default_nettype wire
